@@ rtl/dcls_pkg.sv @@
// ----------------------------------------------------------------------------
// dcls_pkg
// Shared types and codes for the dual-color LED matrix scan engine.
// ----------------------------------------------------------------------------
`default_nettype none

package dcls_pkg;

   // request opcodes
   localparam logic [1:0] OP_WRITE   = 2'd0;
   localparam logic [1:0] OP_READ    = 2'd1;
   localparam logic [1:0] OP_SWAP    = 2'd2;
   localparam logic [1:0] OP_REFRESH = 2'd3;

   // result kinds
   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_CHUNK = 1'b1;

   localparam int BYTE_BITS = 8;

   // one bit fetch issued by the row sequencer
   typedef struct packed {
      logic valid;      // a bit read is issued this cycle
      logic byte_end;   // bit 7 of a byte
      logic frame_end;  // bit 7 of the final byte of the refresh
      logic done;       // sequencer finishes this cycle
   } seq_issue_type;

   // tag that travels alongside the registered memory read
   typedef struct packed {
      logic valid;
      logic kind;
      logic color;
      logic on_matrix;
      logic byte_end;
      logic frame_end;
   } read_tag_type;

endpackage

`default_nettype wire

@@ rtl/dual_color_led_matrix_scan_engine_unit.sv @@
// ----------------------------------------------------------------------------
// dual_color_led_matrix_scan_engine_unit
// Double-buffered red/green framebuffer with a bit-serial row scan output.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. Each result is
//   shown for one cycle with rsp_valid high; the receiver cannot stall it.
//   The store holds one bit per pixel in two RAMs (red, green), each
//   covering both buffers.
//   Write pixel and swap request: taken back to back, no result.
//   Read pixel: busy while its read tag is pending; result registered after the RAM read.
//   Refresh tick: the row sequencer fetches one bit of each color per
//   cycle, one result per byte pair. A scan row of LINES/SCAN_ROWS
//   lines gives (LINES/SCAN_ROWS)*(COLUMNS/8) pairs, 48 at the defaults.
//   After reset a clearing pass fills the store with ones (dark), one bit
//   address per cycle over all 2*LINES*(COLUMNS/8)*8 addresses, 12288 at
//   the defaults. Busy is high during the pass and no item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_color_led_matrix_scan_engine_unit #(
   parameter int COLUMNS   = 96,
   parameter int LINES     = 64,
   parameter int SCAN_ROWS = 16,
   localparam int CW = $clog2(COLUMNS),
   localparam int LW = $clog2(LINES),
   localparam int RW = $clog2(SCAN_ROWS)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire logic [1:0]    req_opcode,
   input  wire logic          req_color,
   input  wire logic [CW-1:0] req_column,
   input  wire logic [LW-1:0] req_line,
   input  wire logic          req_pixel_on,
   output logic               rsp_valid,
   output logic               rsp_kind,
   output logic               rsp_pixel_state,
   output logic               rsp_swap_waiting,
   output logic [7:0]         rsp_red_bits,
   output logic [7:0]         rsp_green_bits,
   output logic [RW-1:0]      rsp_row_select,
   output logic               rsp_last
);

   localparam int BPL   = COLUMNS / 8;
   localparam int DEPTH = 2 * LINES * BPL * 8;
   localparam int AW    = $clog2(DEPTH);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          disp_ff, disp_in;
   logic [RW-1:0] row_ff, row_in;
   logic          swap_ff, swap_in;
   logic [RW-1:0] row_cap_ff, row_cap_in;
   logic          wait_cap_ff, wait_cap_in;

   logic                     accept, on_matrix, pending, seq_start, buf_sel;
   logic [AW-1:0]            pix_base, pix_addr, seq_addr, ram_addr;
   logic                     red_we, green_we, ram_wdata;
   logic                     red_rdata, green_rdata;
   dcls_pkg::seq_issue_type  issue;
   dcls_pkg::read_tag_type   tag;

   always_comb begin
      busy   = (state_ff != ST_IDLE) || pending;
      accept = start && !busy;
      on_matrix = ({1'b0, req_column} < (CW + 1)'(COLUMNS))
               && ({1'b0, req_line} < (LW + 1)'(LINES));
      seq_start = accept && (req_opcode == dcls_pkg::OP_REFRESH);

      // writes go to the drawing buffer, reads look at the displayed one
      buf_sel  = (req_opcode == dcls_pkg::OP_WRITE) ? ~disp_ff : disp_ff;
      pix_base = (buf_sel ? AW'(LINES) : '0) + AW'(req_line);
      pix_addr = AW'(pix_base * AW'(BPL * 8) + AW'(req_column));

      red_we    = 1'b0;
      green_we  = 1'b0;
      ram_wdata = ~req_pixel_on;
      ram_addr  = pix_addr;
      case (state_ff)
         ST_CLEAR: begin
            red_we    = 1'b1;
            green_we  = 1'b1;
            ram_wdata = 1'b1;
            ram_addr  = clr_ff;
         end
         ST_SCAN: begin
            ram_addr = seq_addr;
         end
         default: begin
            if (accept && (req_opcode == dcls_pkg::OP_WRITE) && on_matrix) begin
               red_we   = ~req_color;
               green_we = req_color;
            end
         end
      endcase

      tag = '0;
      if (issue.valid) begin
         tag.valid     = 1'b1;
         tag.kind      = dcls_pkg::KIND_CHUNK;
         tag.byte_end  = issue.byte_end;
         tag.frame_end = issue.frame_end;
      end else if (accept && (req_opcode == dcls_pkg::OP_READ)) begin
         tag.valid     = 1'b1;
         tag.kind      = dcls_pkg::KIND_READ;
         tag.color     = req_color;
         tag.on_matrix = on_matrix;
      end
   end

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      disp_in     = disp_ff;
      row_in      = row_ff;
      swap_in     = swap_ff;
      row_cap_in  = row_cap_ff;
      wait_cap_in = wait_cap_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (issue.done) begin
               state_in = ST_IDLE;
               if (row_ff == RW'(SCAN_ROWS - 1)) begin
                  row_in = '0;
                  if (swap_ff) begin
                     disp_in = ~disp_ff;
                     swap_in = 1'b0;
                  end
               end else begin
                  row_in = row_ff + RW'(1);
               end
            end
         end
         default: begin
            if (accept) begin
               row_cap_in  = row_ff;
               wait_cap_in = swap_ff;
               if (req_opcode == dcls_pkg::OP_SWAP) begin
                  swap_in = 1'b1;
               end
               if (req_opcode == dcls_pkg::OP_REFRESH) begin
                  state_in = ST_SCAN;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         disp_ff  <= 1'b1;
         row_ff   <= '0;
         swap_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         disp_ff  <= disp_in;
         row_ff   <= row_in;
         swap_ff  <= swap_in;
      end
      row_cap_ff  <= row_cap_in;
      wait_cap_ff <= wait_cap_in;
   end

   dcls_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_red_ram (
      .clock (clock),
      .we    (red_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (red_rdata)
   );

   dcls_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_green_ram (
      .clock (clock),
      .we    (green_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (green_rdata)
   );

   dcls_row_seq #(
      .COLUMNS   (COLUMNS),
      .LINES     (LINES),
      .SCAN_ROWS (SCAN_ROWS)
   ) u_row_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (seq_start),
      .start_row (row_ff),
      .disp      (disp_ff),
      .issue     (issue),
      .addr      (seq_addr)
   );

   dcls_shift #(
      .ROW_BITS (RW)
   ) u_shift (
      .clock            (clock),
      .reset            (reset),
      .tag_in           (tag),
      .red_bit          (red_rdata),
      .green_bit        (green_rdata),
      .row              (row_cap_ff),
      .waiting          (wait_cap_ff),
      .pending          (pending),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_pixel_state  (rsp_pixel_state),
      .rsp_swap_waiting (rsp_swap_waiting),
      .rsp_red_bits     (rsp_red_bits),
      .rsp_green_bits   (rsp_green_bits),
      .rsp_row_select   (rsp_row_select),
      .rsp_last         (rsp_last)
   );

`ifndef SYNTHESIS
   a_no_result_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid)
      else $error("result during clearing pass");

   a_issue_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      issue.valid |-> ((state_ff == ST_SCAN) && busy && !red_we && !green_we))
      else $error("bit fetch outside a refresh");

   a_swap_needs_pending: assert property (@(posedge clock) disable iff (reset)
      (disp_ff != $past(disp_ff)) |-> ($past(swap_ff) && (row_ff == '0)))
      else $error("buffer swap without pending request");

   a_last_is_chunk: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_kind == dcls_pkg::KIND_CHUNK))
      else $error("latch mark on a read answer");
`endif

endmodule

`default_nettype wire

@@ rtl/dcls_ram.sv @@
// ----------------------------------------------------------------------------
// dcls_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dcls_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wdata,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ rtl/dcls_row_seq.sv @@
// ----------------------------------------------------------------------------
// dcls_row_seq
// Walks the lines, byte groups, bytes and bits of one scan row and issues
// one bit address per cycle into the pixel store.
// ----------------------------------------------------------------------------
`default_nettype none

module dcls_row_seq #(
   parameter int COLUMNS   = 96,
   parameter int LINES     = 64,
   parameter int SCAN_ROWS = 16,
   localparam int BPL   = COLUMNS / 8,
   localparam int DEPTH = 2 * LINES * BPL * 8,
   localparam int AW    = $clog2(DEPTH),
   localparam int RW    = $clog2(SCAN_ROWS)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [RW-1:0]          start_row,
   input  wire logic                   disp,
   output dcls_pkg::seq_issue_type     issue,
   output logic [AW-1:0]               addr
);

   localparam int BW  = $clog2(BPL);
   localparam int LNW = $clog2((LINES > SCAN_ROWS) ? LINES : SCAN_ROWS) + 1;
   localparam logic [BW-1:0] TOP_START   = BW'(BPL - 1);
   localparam logic [BW-1:0] FIRST_START = BW'((BPL - 1 > 2) ? BPL - 4 : 0);

   logic                  active_ff, active_in;
   logic signed [LNW-1:0] ln_ff, ln_in;
   logic [BW-1:0]         top_ff, top_in;
   logic [BW-1:0]         byte_ff, byte_in;
   logic [2:0]            bit_ff, bit_in;

   logic signed [LNW-1:0] ln_start, ln_next;
   logic [BW-1:0]         down_top, down_first;
   logic                  byte_end, grp_end, last_group, frame_end;
   logic [AW-1:0]         line_base;

   always_comb begin
      ln_start   = LNW'(LINES) - LNW'(SCAN_ROWS) + LNW'(start_row);
      ln_next    = ln_ff - LNW'(SCAN_ROWS);
      down_top   = top_ff - BW'(3) - BW'(1);
      down_first = (down_top > BW'(2)) ? down_top - BW'(3) : '0;
      byte_end   = (bit_ff == 3'd7);
      grp_end    = byte_end && (byte_ff == top_ff);
      last_group = (top_ff <= BW'(3));
      frame_end  = grp_end && last_group && ln_next[LNW-1];

      line_base = (disp ? AW'(LINES) : '0) + AW'(ln_ff[LNW-2:0]);
      addr      = AW'({line_base * AW'(BPL) + AW'(byte_ff), bit_ff});
   end

   always_comb begin
      active_in = active_ff;
      ln_in     = ln_ff;
      top_in    = top_ff;
      byte_in   = byte_ff;
      bit_in    = bit_ff;
      issue     = '0;
      if (start) begin
         active_in = 1'b1;
         ln_in     = ln_start;
         top_in    = TOP_START;
         byte_in   = FIRST_START;
         bit_in    = 3'd0;
      end else if (active_ff) begin
         if (ln_ff[LNW-1]) begin
            // row has no lines at all
            active_in  = 1'b0;
            issue.done = 1'b1;
         end else begin
            issue.valid     = 1'b1;
            issue.byte_end  = byte_end;
            issue.frame_end = frame_end;
            issue.done      = frame_end;
            bit_in          = bit_ff + 3'd1;
            if (byte_end) begin
               if (!grp_end) begin
                  byte_in = byte_ff + BW'(1);
               end else if (!last_group) begin
                  top_in  = down_top;
                  byte_in = down_first;
               end else if (!frame_end) begin
                  ln_in   = ln_next;
                  top_in  = TOP_START;
                  byte_in = FIRST_START;
               end else begin
                  active_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      ln_ff   <= ln_in;
      top_ff  <= top_in;
      byte_ff <= byte_in;
      bit_ff  <= bit_in;
   end

endmodule

`default_nettype wire

@@ rtl/dcls_shift.sv @@
// ----------------------------------------------------------------------------
// dcls_shift
// Bit-serial assembly of red/green bytes from the pixel store and the
// registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dcls_shift #(
   parameter int ROW_BITS = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dcls_pkg::read_tag_type tag_in,
   input  wire logic                  red_bit,
   input  wire logic                  green_bit,
   input  wire logic [ROW_BITS-1:0]   row,
   input  wire logic                  waiting,
   output logic                       pending,
   output logic                       rsp_valid,
   output logic                       rsp_kind,
   output logic                       rsp_pixel_state,
   output logic                       rsp_swap_waiting,
   output logic [7:0]                 rsp_red_bits,
   output logic [7:0]                 rsp_green_bits,
   output logic [ROW_BITS-1:0]        rsp_row_select,
   output logic                       rsp_last
);

   dcls_pkg::read_tag_type tag_ff;
   logic [dcls_pkg::BYTE_BITS-1:0] red_sr_ff, red_sr_in;
   logic [dcls_pkg::BYTE_BITS-1:0] green_sr_ff, green_sr_in;

   logic                valid_ff, valid_in;
   logic                kind_ff, kind_in;
   logic                pstate_ff, pstate_in;
   logic                wait_ff, wait_in;
   logic [7:0]          red_ff, red_in;
   logic [7:0]          green_ff, green_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic                last_ff, last_in;

   logic is_chunk, sel_bit;

   always_comb begin
      is_chunk = tag_ff.valid && (tag_ff.kind == dcls_pkg::KIND_CHUNK);
      sel_bit  = tag_ff.color ? green_bit : red_bit;

      // shift in LSB first: bit 0 ends up at the bottom after the last shift of the byte
      red_sr_in   = is_chunk ? {red_bit, red_sr_ff[7:1]} : red_sr_ff;
      green_sr_in = is_chunk ? {green_bit, green_sr_ff[7:1]} : green_sr_ff;

      valid_in  = tag_ff.valid && (!is_chunk || tag_ff.byte_end);
      kind_in   = kind_ff;
      pstate_in = pstate_ff;
      wait_in   = wait_ff;
      red_in    = red_ff;
      green_in  = green_ff;
      row_in    = row_ff;
      last_in   = last_ff;
      if (valid_in) begin
         kind_in  = tag_ff.kind;
         wait_in  = waiting;
         if (is_chunk) begin
            pstate_in = 1'b0;
            red_in    = red_sr_in;
            green_in  = green_sr_in;
            row_in    = row;
            last_in   = tag_ff.frame_end;
         end else begin
            // stored bits are active low
            pstate_in = tag_ff.on_matrix & ~sel_bit;
            red_in    = '0;
            green_in  = '0;
            row_in    = '0;
            last_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         tag_ff   <= tag_in;
         valid_ff <= valid_in;
      end
      red_sr_ff   <= red_sr_in;
      green_sr_ff <= green_sr_in;
      kind_ff     <= kind_in;
      pstate_ff   <= pstate_in;
      wait_ff     <= wait_in;
      red_ff      <= red_in;
      green_ff    <= green_in;
      row_ff      <= row_in;
      last_ff     <= last_in;
   end

   assign pending          = tag_ff.valid;
   assign rsp_valid        = valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_pixel_state  = pstate_ff;
   assign rsp_swap_waiting = wait_ff;
   assign rsp_red_bits     = red_ff;
   assign rsp_green_bits   = green_ff;
   assign rsp_row_select   = row_ff;
   assign rsp_last         = last_ff;

endmodule

`default_nettype wire

@@ tb/sv/tb_dual_color_led_matrix_scan_engine_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dual_color_led_matrix_scan_engine_unit
// Self-checking bench for the double-buffered LED matrix scan engine.
// A class keeps its own copy of both framebuffers, the scan row and the swap
// flag. It predicts read answers and the 48 byte-pair chunks of each refresh,
// and checks every strobed result in order. A directed opening covers edge
// pixels, off-matrix access, repeated swaps and a full frame of refreshes.
// Random bursts of writes, reads, swaps and refreshes follow.
// ----------------------------------------------------------------------------

typedef struct {
   bit       kind;
   bit       pixel_state;
   bit       swap_waiting;
   bit [7:0] red_bits;
   bit [7:0] green_bits;
   bit [3:0] row_select;
   bit       last;
} scan_result_type;

class framebuffer_scoreboard;
   localparam int COLUMNS        = 96;
   localparam int LINES          = 64;
   localparam int SCAN_ROWS      = 16;
   localparam int BYTES_PER_LINE = COLUMNS / 8;

   // [buffer][color][line][byte], active low
   bit [7:0]        pixel_bytes [2][2][LINES][BYTES_PER_LINE];
   bit              display_sel;
   bit [3:0]        scan_row;
   bit              swap_pending;
   scan_result_type expected_q[$];
   int              errors;

   function new();
      foreach (pixel_bytes[b, c, l, k]) pixel_bytes[b][c][l][k] = 8'hFF;
      display_sel  = 1'b1;
      scan_row     = '0;
      swap_pending = 1'b0;
      errors       = 0;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   function void note_item(logic [1:0] op, bit color, bit [6:0] col, bit [5:0] ln, bit on);
      scan_result_type r;
      bit              on_matrix;
      int              line_idx;
      int              top;
      int              b;
      int              chunks;
      on_matrix = (col < COLUMNS) && (ln < LINES);
      r = '{default: 0};
      chunks = 0;
      case (op)
         dcls_pkg::OP_WRITE: begin
            if (on_matrix)
               pixel_bytes[~display_sel][color][ln][col >> 3][col[2:0]] = ~on;
         end
         dcls_pkg::OP_READ: begin
            r.kind = dcls_pkg::KIND_READ;
            if (on_matrix)
               r.pixel_state = ~pixel_bytes[display_sel][color][ln][col >> 3][col[2:0]];
            r.swap_waiting = swap_pending;
            expected_q.push_back(r);
         end
         dcls_pkg::OP_SWAP: begin
            swap_pending = 1'b1;
         end
         default: begin
            // top line of the scan row first, byte groups high to low
            for (line_idx = LINES - SCAN_ROWS + scan_row; line_idx >= 0;
                 line_idx -= SCAN_ROWS) begin
               for (top = BYTES_PER_LINE - 1; top >= 0; top -= 4) begin
                  for (b = top - 3; b <= top; b++) begin
                     if (b >= 0) begin
                        r.kind         = dcls_pkg::KIND_CHUNK;
                        r.swap_waiting = swap_pending;
                        r.red_bits     = pixel_bytes[display_sel][0][line_idx][b];
                        r.green_bits   = pixel_bytes[display_sel][1][line_idx][b];
                        r.row_select   = scan_row;
                        expected_q.push_back(r);
                        chunks++;
                     end
                  end
               end
            end
            if (chunks > 0)
               expected_q[expected_q.size() - 1].last = 1'b1;
            if (scan_row == SCAN_ROWS - 1) begin
               scan_row = '0;
               if (swap_pending) begin
                  display_sel  = ~display_sel;
                  swap_pending = 1'b0;
               end
            end else begin
               scan_row++;
            end
         end
      endcase
   endfunction

   function void check_field(string name, int expected, int actual);
      if (expected != actual) begin
         $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
         errors++;
      end
   endfunction

   function void check_result(scan_result_type got);
      scan_result_type want;
      if (expected_q.size() == 0) begin
         $error("unexpected result: kind %0d row %0d", got.kind, got.row_select);
         errors++;
         return;
      end
      want = expected_q.pop_front();
      check_field("rsp_kind", want.kind, got.kind);
      check_field("rsp_pixel_state", want.pixel_state, got.pixel_state);
      check_field("rsp_swap_waiting", want.swap_waiting, got.swap_waiting);
      check_field("rsp_red_bits", want.red_bits, got.red_bits);
      check_field("rsp_green_bits", want.green_bits, got.green_bits);
      check_field("rsp_row_select", want.row_select, got.row_select);
      check_field("rsp_last", want.last, got.last);
   endfunction
endclass

module tb_dual_color_led_matrix_scan_engine_unit;

   localparam int RANDOM_ITEMS = 446;
   localparam int IDLE_LIMIT   = 60000;

   logic       clock        = 1'b0;
   logic       reset        = 1'b1;
   logic       start        = 1'b0;
   logic       busy;
   logic [1:0] req_opcode   = dcls_pkg::OP_WRITE;
   logic       req_color    = 1'b0;
   logic [6:0] req_column   = '0;
   logic [5:0] req_line     = '0;
   logic       req_pixel_on = 1'b0;
   logic       rsp_valid;
   logic       rsp_kind;
   logic       rsp_pixel_state;
   logic       rsp_swap_waiting;
   logic [7:0] rsp_red_bits;
   logic [7:0] rsp_green_bits;
   logic [3:0] rsp_row_select;
   logic       rsp_last;

   framebuffer_scoreboard frame_sb = new();
   int burst_left  = 0;
   int idle_cycles = 0;

   dual_color_led_matrix_scan_engine_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_color        (req_color),
      .req_column       (req_column),
      .req_line         (req_line),
      .req_pixel_on     (req_pixel_on),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_pixel_state  (rsp_pixel_state),
      .rsp_swap_waiting (rsp_swap_waiting),
      .rsp_red_bits     (rsp_red_bits),
      .rsp_green_bits   (rsp_green_bits),
      .rsp_row_select   (rsp_row_select),
      .rsp_last         (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // hand one item to the engine; idle between bursts
   task automatic send_item(input logic [1:0] op, input bit color, input bit [6:0] col,
                            input bit [5:0] ln, input bit on);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 10);
      end
      req_opcode   <= op;
      req_color    <= color;
      req_column   <= col;
      req_line     <= ln;
      req_pixel_on <= on;
      start        <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      frame_sb.note_item(op, color, col, ln, on);
      burst_left--;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         frame_sb.check_result('{rsp_kind, rsp_pixel_state, rsp_swap_waiting, rsp_red_bits,
                                 rsp_green_bits, rsp_row_select, rsp_last});
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("** dual_color_led_matrix_scan_engine_unit: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      int       i;
      int       pick;
      logic [1:0] op;
      bit [6:0] col;
      bit [5:0] ln;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: corner pixels, off-matrix access, repeated swap, full frame
      send_item(dcls_pkg::OP_READ, 1'b0, 7'd0, 6'd0, 1'b1);
      send_item(dcls_pkg::OP_WRITE, 1'b0, 7'd0, 6'd0, 1'b1);
      send_item(dcls_pkg::OP_WRITE, 1'b1, 7'd95, 6'd63, 1'b1);
      send_item(dcls_pkg::OP_WRITE, 1'b0, 7'd127, 6'd63, 1'b1);
      send_item(dcls_pkg::OP_SWAP, 1'b0, 7'd0, 6'd0, 1'b0);
      send_item(dcls_pkg::OP_SWAP, 1'b1, 7'd127, 6'd63, 1'b1);
      for (i = 0; i < 16; i++)
         send_item(dcls_pkg::OP_REFRESH, 1'b0, 7'd0, 6'd0, 1'b0);
      send_item(dcls_pkg::OP_READ, 1'b0, 7'd0, 6'd0, 1'b0);
      send_item(dcls_pkg::OP_READ, 1'b1, 7'd127, 6'd0, 1'b0);

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55)      op = dcls_pkg::OP_WRITE;
         else if (pick < 75) op = dcls_pkg::OP_READ;
         else if (pick < 82) op = dcls_pkg::OP_SWAP;
         else                op = dcls_pkg::OP_REFRESH;
         // keep half the accesses in a small corner so reads hit written pixels
         if ($urandom_range(0, 1) == 0) begin
            col = 7'($urandom_range(0, 127));
            ln  = 6'($urandom_range(0, 63));
         end else begin
            col = 7'($urandom_range(0, 15));
            ln  = 6'($urandom_range(0, 3));
         end
         send_item(op, 1'($urandom_range(0, 1)), col, ln, 1'($urandom_range(0, 1)));
      end

      start <= 1'b0;
      while (frame_sb.pending() > 0) @(posedge clock);
      repeat (12) @(posedge clock);

      if (frame_sb.errors == 0 && frame_sb.pending() == 0) begin
         $display("** dual_color_led_matrix_scan_engine_unit: PASSED **");
      end else begin
         $display("** dual_color_led_matrix_scan_engine_unit: FAILED **");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/dcls_pkg.sv
rtl/dcls_ram.sv
rtl/dcls_row_seq.sv
rtl/dcls_shift.sv
rtl/dual_color_led_matrix_scan_engine_unit.sv
tb/sv/tb_dual_color_led_matrix_scan_engine_unit.sv
